@@ src/ssa_pkg.sv @@
`timescale 1ns / 1ps

package ssa_pkg;

  // Default structural bounds
  localparam int DEF_MAX_SEGMENTS = 16;
  localparam int DEF_MAX_LAYERS   = 256;

  // Fixed field widths
  localparam int SEG_FIELD_W   = 4;
  localparam int LAYER_FIELD_W = 8;
  localparam int STATUS_W      = 2;
  localparam int TDATA_W       = 16;

  // Configuration port
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;
  localparam int CFG_LAYERS_W = 9;
  localparam int CFG_LIMIT_W  = 5;

  localparam logic [CFG_IDX_W-1:0]    REG_LAYERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0]    REG_LIMIT  = 1'd1;
  localparam logic [CFG_LAYERS_W-1:0] LAYERS_RST = 9'd256;
  localparam logic [CFG_LIMIT_W-1:0]  LIMIT_RST  = 5'd0;

  // Request kinds
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED  = 2'd0,
    STAT_NOSPACE  = 2'd1,
    STAT_RELEASED = 2'd2,
    STAT_REJECTED = 2'd3
  } ssa_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ssa_state_t;

endpackage

@@ src/ssa_stack_mem.sv @@
`timescale 1ns / 1ps

module ssa_stack_mem
  import ssa_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_SEGMENTS * DEF_MAX_LAYERS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [LAYER_FIELD_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [LAYER_FIELD_W-1:0] rd_data
);

  logic [LAYER_FIELD_W-1:0] mem [DEPTH];
  logic [LAYER_FIELD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/segmented_slot_allocator_core.sv @@
`timescale 1ns / 1ps
// Segmented slot allocator.
// Input stream (in_*): one beat per request. in_tuser is the request kind
// (allocate or release); in_tdata carries the slot being released.
// Output stream (out_*): exactly one beat per request. out_tuser is the
// status (granted, no space, released, release rejected); out_tdata carries
// the granted segment and layer, zero for any status other than granted.
// Each segment keeps a LIFO of free layers in the stack RAM; a fresh segment
// is full, position p implicitly holding layer p, tracked by a low-water mark.
// Timing: a request is taken in IDLE, decided in EXEC (counts updated, stack
// RAM read or written) and presented in RESP once the RAM read data is back.
// Requests are taken one at a time, at the pace of the IDLE/EXEC/RESP walk
// around the RAM read; the beat is loaded from the decision registers into
// the output register as RESP is left, and is then offered on out_*.
// A stalled receiver only holds the finished beat in the output register; the
// next request is still accepted and decided, and waits in RESP.
// Reset (rst_n low, synchronous): no segment active, all counts zero, registers
// at their defaults; the stack RAM needs no clearing pass. The user must write
// configuration via cfg_we/cfg_addr/cfg_data only while idle (not enforced).

module segmented_slot_allocator_core
  import ssa_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_LAYERS   = DEF_MAX_LAYERS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,  // [3:0] release_segment, [11:4] release_layer
  input  logic                  in_tuser,  // [0] func
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata, // [3:0] granted_segment, [11:4] granted_layer
  output logic [STATUS_W-1:0]   out_tuser  // [1:0] status
);

  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int AS_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
  localparam int DEPTH  = MAX_SEGMENTS * MAX_LAYERS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = (AS_W > SEG_FIELD_W) ? AS_W : SEG_FIELD_W;

  // configuration registers
  logic [CFG_LAYERS_W-1:0] cfg_layers_r;
  logic [CFG_LIMIT_W-1:0]  cfg_limit_r;

  // segment bookkeeping
  logic [AS_W-1:0]  active_r, active_nxt;
  logic [CNT_W-1:0] free_count_r [MAX_SEGMENTS];
  logic [CNT_W-1:0] low_water_r  [MAX_SEGMENTS];

  // request held for the decision step
  logic                     func_r;
  logic [SEG_FIELD_W-1:0]   rseg_r;
  logic [LAYER_FIELD_W-1:0] rlay_r;

  // decision held until the beat is presented
  ssa_status_t              pend_status_r, pend_status_nxt;
  logic [SEG_FIELD_W-1:0]   pend_seg_r, pend_seg_nxt;
  logic                     pend_impl_r, pend_impl_nxt;
  logic [LAYER_FIELD_W-1:0] pend_layer_r, pend_layer_nxt;

  // output register
  logic                     out_valid_r;
  ssa_status_t              out_status_r;
  logic [SEG_FIELD_W-1:0]   out_seg_r;
  logic [LAYER_FIELD_W-1:0] out_layer_r;

  ssa_state_t state_r, state_nxt;
  logic       accept, exec_en, resp_load;

  // decision logic
  logic [CNT_W-1:0]  eff_layers;
  logic [AS_W-1:0]   eff_limit;
  logic              pe_found;
  logic [SEG_W-1:0]  pe_idx;
  logic [SEG_W-1:0]  alloc_idx, rel_idx, upd_idx;
  logic              alloc_new;
  logic [CNT_W-1:0]  alloc_base, alloc_q, alloc_lw;
  logic              rel_ok;
  logic              upd_en, lw_en;
  logic [CNT_W-1:0]  cnt_nxt, lw_nxt;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [LAYER_FIELD_W-1:0] mem_rdata;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_layers_r <= LAYERS_RST;
      cfg_limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LAYERS: cfg_layers_r <= CFG_LAYERS_W'(cfg_data);
        REG_LIMIT:  cfg_limit_r  <= cfg_data[CFG_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // size 0 acts as 1, clipped to the RAM row length
  always_comb begin
    if (cfg_layers_r == '0) begin
      eff_layers = CNT_W'(1);
    end else if (int'(cfg_layers_r) > MAX_LAYERS) begin
      eff_layers = CNT_W'(MAX_LAYERS);
    end else begin
      eff_layers = CNT_W'(cfg_layers_r);
    end
  end

  always_comb begin
    if (cfg_limit_r == '0 || int'(cfg_limit_r) > MAX_SEGMENTS) begin
      eff_limit = AS_W'(MAX_SEGMENTS);
    end else begin
      eff_limit = AS_W'(cfg_limit_r);
    end
  end

  // --------------------------------------------------------- state machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    exec_en   = 1'b0;
    resp_load = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: exec_en   = 1'b1;
      ST_RESP: resp_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_tuser;
      rseg_r <= in_tdata[SEG_FIELD_W-1:0];
      rlay_r <= in_tdata[SEG_FIELD_W +: LAYER_FIELD_W];
    end
  end

  // ---------------------------------------------------------------- decide
  // first active segment with a free slot
  always_comb begin
    pe_found = 1'b0;
    pe_idx   = '0;
    for (int s = MAX_SEGMENTS - 1; s >= 0; s--) begin
      if (AS_W'(s) < active_r && free_count_r[s] != '0) begin
        pe_found = 1'b1;
        pe_idx   = SEG_W'(s);
      end
    end
  end

  always_comb begin
    alloc_new  = !pe_found && (active_r < eff_limit);
    alloc_idx  = pe_found ? pe_idx : SEG_W'(active_r);
    alloc_base = alloc_new ? eff_layers : free_count_r[alloc_idx];
    alloc_lw   = alloc_new ? eff_layers : low_water_r[alloc_idx];
    alloc_q    = alloc_base - CNT_W'(1);

    rel_idx = SEG_W'(rseg_r);
    rel_ok  = (CW'(rseg_r) < CW'(active_r)) && (int'(rseg_r) < MAX_SEGMENTS) &&
              (free_count_r[rel_idx] < eff_layers);

    active_nxt      = active_r;
    upd_en          = 1'b0;
    lw_en           = 1'b0;
    upd_idx         = alloc_idx;
    cnt_nxt         = alloc_q;
    lw_nxt          = alloc_q;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    pend_status_nxt = STAT_NOSPACE;
    pend_seg_nxt    = '0;
    pend_impl_nxt   = 1'b1;
    pend_layer_nxt  = '0;

    if (func_r == FUNC_ALLOC) begin
      if (pe_found || alloc_new) begin
        upd_en          = 1'b1;
        lw_en           = alloc_new || (alloc_q < alloc_lw);
        pend_status_nxt = STAT_GRANTED;
        pend_seg_nxt    = SEG_FIELD_W'(alloc_idx);
        pend_impl_nxt   = alloc_q < alloc_lw;
        pend_layer_nxt  = LAYER_FIELD_W'(alloc_q);
        mem_re          = !(alloc_q < alloc_lw);
        if (alloc_new) begin
          active_nxt = active_r + AS_W'(1);
        end
      end
    end else begin
      upd_idx = rel_idx;
      cnt_nxt = free_count_r[rel_idx] + CNT_W'(1);
      if (rel_ok) begin
        upd_en          = 1'b1;
        mem_we          = 1'b1;
        pend_status_nxt = STAT_RELEASED;
      end else begin
        pend_status_nxt = STAT_REJECTED;
      end
    end
  end

  assign mem_raddr = ADDR_W'(alloc_idx) * ADDR_W'(MAX_LAYERS) + ADDR_W'(alloc_q);
  assign mem_waddr = ADDR_W'(rel_idx) * ADDR_W'(MAX_LAYERS) + ADDR_W'(free_count_r[rel_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int s = 0; s < MAX_SEGMENTS; s++) begin
        free_count_r[s] <= '0;
        low_water_r[s]  <= '0;
      end
    end else if (exec_en) begin
      active_r <= active_nxt;
      if (upd_en) begin
        free_count_r[upd_idx] <= cnt_nxt;
      end
      if (lw_en) begin
        low_water_r[upd_idx] <= lw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      pend_status_r <= pend_status_nxt;
      pend_seg_r    <= pend_seg_nxt;
      pend_impl_r   <= pend_impl_nxt;
      pend_layer_r  <= pend_layer_nxt;
    end
  end

  ssa_stack_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (exec_en && mem_we),
    .wr_addr (mem_waddr),
    .wr_data (rlay_r),
    .rd_en   (exec_en && mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status_r <= pend_status_r;
      out_seg_r    <= pend_seg_r;
      out_layer_r  <= pend_impl_r ? pend_layer_r : mem_rdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(TDATA_W - SEG_FIELD_W - LAYER_FIELD_W)'(0), out_layer_r, out_seg_r};

  // ------------------------------------------------------------ assertions
  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= AS_W'(MAX_SEGMENTS))
    else $error("active segment count beyond bound");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready ##1 !in_tready)
    else $error("request taken while another is in flight");

  a_zero_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_GRANTED |-> out_seg_r == '0 && out_layer_r == '0)
    else $error("slot fields set on a beat that is not a grant");

  a_grow_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
    exec_en && active_nxt != active_r |-> pend_status_nxt == STAT_GRANTED)
    else $error("segment activated without a grant");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
  import ssa_pkg::*;
();

  // Watchdog: cycles in a row with no beat on either stream. The slowest
  // legal item is a random send gap, the core's IDLE/EXEC/RESP walk and a
  // random receive stall, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGS  = DEF_MAX_SEGMENTS;
  localparam int SLOTS = DEF_MAX_LAYERS;

  typedef struct packed {
    logic       func;
    logic [3:0] seg;
    logic [7:0] layer;
  } slot_req_t;

  typedef struct packed {
    ssa_status_t status;
    logic [3:0]  seg;
    logic [7:0]  layer;
  } slot_outcome_t;

  typedef struct packed {
    logic [3:0] seg;
    logic [7:0] layer;
  } slot_ref_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;  // [3:0] release_segment, [11:4] release_layer
  logic                  in_tuser;  // [0] func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata; // [3:0] granted_segment, [11:4] granted_layer
  logic [STATUS_W-1:0]   out_tuser; // [1:0] status

  segmented_slot_allocator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------
  // Allocator shadow state: configuration, segment counts, stack memory
  // ---------------------------------------------------------------------
  logic [CFG_LAYERS_W-1:0] cfg_layers;
  logic [CFG_LIMIT_W-1:0]  cfg_limit;
  int unsigned             active_cnt;
  int unsigned             free_cnt [SEGS];
  int unsigned             low_mark [SEGS];
  logic [7:0]              stack_mem [SEGS][SLOTS];

  slot_outcome_t awaited_outcomes[$]; // outcomes still owed by the core, oldest first
  slot_ref_t     held_slots[$];       // granted slots the stimulus may hand back
  slot_outcome_t last_oc;
  slot_outcome_t due_oc;
  int            err_cnt = 0;
  int            idle_cycles = 0;
  bit            sender_idle;
  bit            stall_on;

  // Effective segment size: zero acts as one, oversize clamps to the bound
  function automatic int unsigned slot_span();
    int unsigned l;
    l = 32'(cfg_layers);
    if (l == 0) l = 1;
    if (l > SLOTS) l = SLOTS;
    return l;
  endfunction

  // Effective segment limit: zero or oversize means every segment
  function automatic int unsigned segment_cap();
    int unsigned m;
    m = 32'(cfg_limit);
    if (m == 0 || m > SEGS) m = SEGS;
    return m;
  endfunction

  // Works out the outcome of one request and moves the shadow state on
  task automatic decide_slot(input slot_req_t rq, output slot_outcome_t oc);
    int unsigned s;
    int unsigned q;
    int unsigned span;
    bit          hit;
    span      = slot_span();
    hit       = 1'b0;
    s         = 0;
    oc.status = STAT_NOSPACE;
    oc.seg    = '0;
    oc.layer  = '0;
    if (rq.func == FUNC_ALLOC) begin
      // first active segment with a free slot, lowest number wins
      while (!hit && s < active_cnt) begin
        if (free_cnt[s] != 0) hit = 1'b1;
        else s++;
      end
      // none free: open a fresh segment, full, if the limit allows
      if (!hit && active_cnt < segment_cap()) begin
        s           = active_cnt;
        free_cnt[s] = span;
        low_mark[s] = span;
        active_cnt++;
        hit         = 1'b1;
      end
      if (hit) begin
        q         = free_cnt[s] - 1;
        oc.status = STAT_GRANTED;
        oc.seg    = s[3:0];
        // below the low-water mark position p still implicitly holds p
        if (q < low_mark[s]) begin
          oc.layer    = q[7:0];
          low_mark[s] = q;
        end else begin
          oc.layer = stack_mem[s][q];
        end
        free_cnt[s] = q;
      end
    end else begin
      if (rq.seg >= active_cnt || free_cnt[rq.seg] >= span) begin
        oc.status = STAT_REJECTED;
      end else begin
        stack_mem[rq.seg][free_cnt[rq.seg]] = rq.layer;
        free_cnt[rq.seg]++;
        oc.status = STAT_RELEASED;
      end
    end
  endtask

  function automatic slot_req_t mk_req(input logic func, input logic [3:0] seg,
                                       input logic [7:0] layer);
    slot_req_t r;
    r.func  = func;
    r.seg   = seg;
    r.layer = layer;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  // Sends one beat, with an optional random gap first. Called at a rising
  // edge; returns at the edge that accepted the beat, valid still high, so
  // the next call can keep it high without a drop in the same step.
  task automatic send_req(input slot_req_t rq);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq.func;
    in_tdata  <= {{(TDATA_W-12){1'b0}}, rq.layer, rq.seg};
    do @(posedge clk); while (!in_tready);
    decide_slot(rq, last_oc);
    awaited_outcomes.push_back(last_oc);
    if (last_oc.status == STAT_GRANTED) held_slots.push_back({last_oc.seg, last_oc.layer});
  endtask

  task automatic take_slot();
    send_req(mk_req(FUNC_ALLOC, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
  endtask

  task automatic return_slot(input logic [3:0] seg, input logic [7:0] layer);
    send_req(mk_req(FUNC_RELEASE, seg, layer));
  endtask

  // Drops valid and waits until every owed beat is back, plus the core's
  // latency so nothing is in flight before a register write.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers, one per edge; only ever called once quiet.
  task automatic set_config(input logic [CFG_LAYERS_W-1:0] layers,
                            input logic [CFG_LIMIT_W-1:0] seg_limit);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_LAYERS;
    cfg_data <= layers;
    @(posedge clk);
    cfg_layers = layers;
    cfg_addr <= REG_LIMIT;
    cfg_data <= {{(CFG_DATA_W-CFG_LIMIT_W){1'b0}}, seg_limit};
    @(posedge clk);
    cfg_limit = seg_limit;
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, then the checker
  // ---------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH %0t: %s got %0d, want %0d", $time, field, got, want);
    err_cnt++;
  endtask

  // Every result beat is matched against the oldest owed outcome
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("unexpected result beat, status", int'(out_tuser), -1);
      end else begin
        due_oc = awaited_outcomes.pop_front();
        if (out_tuser !== due_oc.status)
          report_mismatch("status", int'(out_tuser), int'(due_oc.status));
        if (out_tdata[3:0] !== due_oc.seg)
          report_mismatch("granted_segment", int'(out_tdata[3:0]), int'(due_oc.seg));
        if (out_tdata[11:4] !== due_oc.layer)
          report_mismatch("granted_layer", int'(out_tdata[11:4]), int'(due_oc.layer));
      end
    end
  end

  // No beat on either side for too long: the core has hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("segmented_slot_allocator_core regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Reset registers: first grant comes from a fresh 256-slot segment 0,
  // top of stack first. Release fields all ones must be ignored on allocate.
  task automatic test_reset_defaults();
    return_slot(4'd0, 8'd0);     // nothing active yet: rejected
    send_req(mk_req(FUNC_ALLOC, 4'hF, 8'hFF));
    send_req(mk_req(FUNC_ALLOC, 4'h0, 8'h00));
  endtask

  // LIFO order, unchecked layer values, full and inactive segments
  task automatic test_release_stack();
    return_slot(4'd0, 8'hA5);
    take_slot();                 // comes straight back as A5
    return_slot(4'd0, 8'h5A);
    return_slot(4'd0, 8'hFF);    // segment 0 full again
    return_slot(4'd0, 8'h00);    // full: rejected
    return_slot(4'd1, 8'h12);    // first inactive segment
    return_slot(4'd15, 8'hFF);   // last segment, inactive
    take_slot();
  endtask

  // Drain segment 0 under a limit of one, then grow with a zero size,
  // then lower the limit below the active count and enlarge the size.
  task automatic test_exhaust_and_grow();
    int n;
    wait_quiet();
    n = 0;
    do begin
      take_slot();
      n++;
    end while (last_oc.status != STAT_NOSPACE && n < 300);
    wait_quiet();
    set_config(9'd0, 5'd3);
    take_slot();                 // new segment of one slot
    take_slot();
    take_slot();                 // limit reached: no space
    return_slot(4'd1, 8'h3C);
    return_slot(4'd1, 8'hC3);    // one-slot segment already full
    take_slot();
    wait_quiet();
    set_config(9'd300, 5'd2);    // oversize size, limit under active count
    take_slot();                 // nothing free, no new segment
    return_slot(4'd2, 8'h01);
    return_slot(4'd2, 8'h02);    // accepted: size is now the full bound
    take_slot();
  endtask

  // Random mix under one setting: allocations at alloc_pct percent, otherwise
  // mostly hand-backs of granted slots, some stray releases with random fields.
  task automatic run_mix(input logic [CFG_LAYERS_W-1:0] layers,
                         input logic [CFG_LIMIT_W-1:0] seg_limit,
                         input int count, input int alloc_pct,
                         input bit gaps, input bit stalls);
    int        idx;
    slot_ref_t pick;
    wait_quiet();
    set_config(layers, seg_limit);
    sender_idle = gaps;
    stall_on    = stalls;
    repeat (count) begin
      if ($urandom_range(0, 199) == 0) wait_quiet();
      if ($urandom_range(0, 99) < alloc_pct) begin
        take_slot();
      end else if (held_slots.size() != 0 && $urandom_range(0, 9) < 8) begin
        idx  = $urandom_range(0, held_slots.size() - 1);
        pick = held_slots[idx];
        held_slots.delete(idx);
        return_slot(pick.seg, pick.layer);
      end else begin
        return_slot(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    sender_idle = 1'b1;
    stall_on    = 1'b1;
    cfg_layers  = LAYERS_RST;
    cfg_limit   = LIMIT_RST;
    active_cnt  = 0;
    for (int s = 0; s < SEGS; s++) begin
      free_cnt[s] = 0;
      low_mark[s] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_release_stack();
    // allocation-heavy: empties the big first segment, then no space
    run_mix(9'd256, 5'd1, 400, 90, 1'b1, 1'b1);
    test_exhaust_and_grow();
    run_mix(9'd4,   5'd6,  250, 60, 1'b1, 1'b1);
    run_mix(9'd0,   5'd10, 200, 55, 1'b1, 1'b0);
    run_mix(9'd2,   5'd16, 200, 65, 1'b0, 1'b1);
    // release-heavy with every size bit set: stacks refill with stray layers
    run_mix(9'h1FF, 5'd31, 200, 30, 1'b1, 1'b1);
    // closing stretch at full rate, no gaps or stalls
    run_mix(9'd1,   5'd0,  200, 50, 1'b0, 1'b0);

    wait_quiet();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("segmented_slot_allocator_core regression: pass");
    end else begin
      $display("segmented_slot_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
